@@ rtl/ura_pkg.sv @@
package ura_pkg;

  // Sizes of the conversion.
  localparam int VALUE_BITS   = 32;
  localparam int MAX_DIGITS   = 32;
  localparam int IN_VALUE_W   = 32;
  localparam int DIGIT_CHAR_W = 6;
  localparam int DIGIT_W      = 4;
  localparam int RADIX_W      = 4;

  // Configuration port.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_LSB = 2;
  localparam logic REG_RADIX = 1'b0;

  // Bits of the input field that take part in the conversion.
  localparam int USE_BITS = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  // The divider retires DIV_STEP dividend bits per cycle.
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_BITS   = DIV_CYCLES * DIV_STEP;
  localparam int DCYC_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Digit count and digit store pointer.
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int PTR_W = $clog2(MAX_DIGITS);

  localparam logic [RADIX_W-1:0]      RADIX_RESET = 4'd10;
  localparam logic [RADIX_W-1:0]      RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0]      RADIX_MAX   = 4'd10;
  localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [DIGIT_CHAR_W-1:0] ASCII_NINE  = 6'd57;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FETCH,
    ST_EMIT
  } ura_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div;
    logic rd_init;
    logic fetch;
    logic advance;
  } ura_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic cnt_full;
    logic rd_zero;
  } ura_stat_t;

  // Clamp the programmed base into two through ten.
  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

@@ rtl/ura_if.sv @@
// Input channel: one value to convert per item.
interface ura_in_if;
  import ura_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one ASCII digit per item.
interface ura_out_if;
  import ura_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DIGIT_CHAR_W-1:0] digit_char;
  logic                    last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ rtl/unsigned_radix_to_ascii_unit.sv @@
// Converts an unsigned value to ASCII digits in a programmable base (two through
// ten, clamped), most significant digit first, with last set on the final digit;
// zero gives the single digit '0'. One value is handled at a time: the divider
// (8 dividend bits per cycle) produces every digit in turn, each followed by a
// check state, and the digits are then read back from the single-port digit store
// and presented one by one, where the output side may stall each of them. The
// radix register sits at byte address 0 and must be written while the block is
// idle.
module unsigned_radix_to_ascii_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  ura_in_if.sink                           in_ch,
  ura_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ura_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ura_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import ura_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  ura_cmd_t           cmd;
  ura_stat_t          stat;
  logic               cfg_wr;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_IDX_LSB] == REG_RADIX)) begin
      radix_r <= cfg_pwdata[RADIX_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_IDX_LSB] == REG_RADIX) ?
                      CFG_DATA_W'(radix_r) : '0;

  // Sequencer.
  ura_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Divider, digit store and output data.
  ura_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .value      (in_ch.value),
    .radix      (radix_r),
    .stat       (stat),
    .digit_char (out_ch.digit_char),
    .last       (out_ch.last)
  );

`ifndef SYNTHESIS
  // Input and output never overlap: one value is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a digit is pending");

  // Every presented character is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.digit_char >= ASCII_ZERO && out_ch.digit_char <= ASCII_NINE))
    else $error("digit character out of range");

  // Taking the final digit frees the block for the next value.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block not idle after final digit");
`endif

endmodule

@@ rtl/ura_ctrl.sv @@
module ura_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  ura_pkg::ura_stat_t stat,
  output ura_pkg::ura_cmd_t  cmd
);
  import ura_pkg::*;

  ura_state_t state_r;
  ura_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.quot_zero || stat.cnt_full) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          state_nxt = stat.rd_zero ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_CHECK: begin
        cmd.rd_init = stat.quot_zero || stat.cnt_full;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !stat.rd_zero;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/ura_dp.sv @@
module ura_dp (
  input  logic                                clk,
  input  ura_pkg::ura_cmd_t                   cmd,
  input  logic [ura_pkg::IN_VALUE_W-1:0]      value,
  input  logic [ura_pkg::RADIX_W-1:0]         radix,
  output ura_pkg::ura_stat_t                  stat,
  output logic [ura_pkg::DIGIT_CHAR_W-1:0]    digit_char,
  output logic                                last
);
  import ura_pkg::*;

  logic [PAD_BITS-1:0]  quot_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [RADIX_W-1:0]   base_r;
  logic [DCYC_W-1:0]    dcyc_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [DIGIT_W-1:0]   rd_data_r;
  logic [DIGIT_W-1:0]   digit_mem_r [MAX_DIGITS];

  logic [DIGIT_W-1:0]   rem_nxt;
  logic [DIV_STEP-1:0]  qbits;
  logic [CNT_W-1:0]     cnt_m1;

  // Restoring division of DIV_STEP dividend bits by the latched base.
  always_comb begin : div_step
    logic [DIGIT_W:0] trial;
    rem_nxt = rem_r;
    qbits   = '0;
    trial   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_nxt, quot_r[PAD_BITS-1-i]};
      if (trial >= {1'b0, base_r}) begin
        trial              = trial - {1'b0, base_r};
        qbits[DIV_STEP-1-i] = 1'b1;
      end
      rem_nxt = trial[DIGIT_W-1:0];
    end
  end

  assign stat.div_last  = (dcyc_r == DCYC_W'(DIV_CYCLES - 1));
  assign stat.quot_zero = (quot_r == '0);
  assign stat.cnt_full  = (cnt_r == CNT_W'(MAX_DIGITS));
  assign stat.rd_zero   = (rd_ptr_r == '0);

  assign cnt_m1 = cnt_r - CNT_W'(1);

  // Quotient, remainder and digit count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= PAD_BITS'(value[USE_BITS-1:0]);
      rem_r  <= '0;
      base_r <= effective_radix(radix);
      dcyc_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div) begin
      quot_r <= {quot_r[PAD_BITS-DIV_STEP-1:0], qbits};
      if (stat.div_last) begin
        rem_r  <= '0;
        dcyc_r <= '0;
        cnt_r  <= cnt_r + CNT_W'(1);
      end else begin
        rem_r  <= rem_nxt;
        dcyc_r <= dcyc_r + DCYC_W'(1);
      end
    end
  end

  // Digit store: written least significant digit first.
  always_ff @(posedge clk) begin
    if (cmd.div && stat.div_last) begin
      digit_mem_r[cnt_r[PTR_W-1:0]] <= rem_nxt;
    end
  end

  // Read back from the most significant digit down.
  always_ff @(posedge clk) begin
    if (cmd.rd_init) begin
      rd_ptr_r <= cnt_m1[PTR_W-1:0];
    end else if (cmd.advance) begin
      rd_ptr_r <= rd_ptr_r - PTR_W'(1);
    end
    if (cmd.fetch) begin
      rd_data_r <= digit_mem_r[rd_ptr_r];
    end
  end

  assign digit_char = ASCII_ZERO + DIGIT_CHAR_W'(rd_data_r);
  assign last       = stat.rd_zero;

endmodule

@@ dv/unsigned_radix_to_ascii_unit_tb.sv @@
module unsigned_radix_to_ascii_unit_tb;
  import ura_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int IDLE_PERCENT    = 27;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 260;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASE_VALUES    = 22;
  localparam int UNUSED_REG_IDX  = 1;

  // One expected character of the converted text.
  typedef struct packed {
    logic [DIGIT_CHAR_W-1:0] digit_char;
    logic                    last;
  } digit_t;

  // Spells each accepted value in the current base and checks the characters
  // that come back against that text, oldest first.
  class digit_ledger;
    logic [RADIX_W-1:0] radix_reg;
    digit_t             pending[$];
    int                 mismatches;
    int                 values_noted;
    int                 digits_checked;
    bit [15:0]          bases_used;

    function new();
      radix_reg      = RADIX_RESET;
      mismatches     = 0;
      values_noted   = 0;
      digits_checked = 0;
      bases_used     = '0;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    // Out-of-range base settings saturate to the nearest legal base.
    function logic [RADIX_W-1:0] effective_base();
      logic [RADIX_W-1:0] b;
      b = radix_reg;
      if (b < RADIX_MIN) begin
        b = RADIX_MIN;
      end else if (b > RADIX_MAX) begin
        b = RADIX_MAX;
      end
      return b;
    endfunction

    function void note_value(logic [IN_VALUE_W-1:0] v);
      logic [RADIX_W-1:0]    b;
      logic [IN_VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0]    found[$];
      digit_t                d;
      int                    k;
      b    = effective_base();
      rest = v;
      // Digits are found least significant first by repeated division.
      if (rest == '0) begin
        found.push_back('0);
      end
      while (rest != '0 && found.size() < MAX_DIGITS) begin
        found.push_back(DIGIT_W'(rest % b));
        rest = rest / b;
      end
      // They leave most significant first, with last on the final one.
      for (k = found.size() - 1; k >= 0; k--) begin
        d.digit_char = ASCII_ZERO + DIGIT_CHAR_W'(found[k]);
        d.last       = (k == 0);
        pending.push_back(d);
      end
      bases_used[b] = 1'b1;
      values_noted++;
    endfunction

    function void check_digit(logic [DIGIT_CHAR_W-1:0] ch, logic lst);
      digit_t want;
      if (pending.size() == 0) begin
        $error("digit_char %0d with last %0b arrived with no digit expected", ch, lst);
        mismatches++;
      end else begin
        want = pending.pop_front();
        digits_checked++;
        if (ch !== want.digit_char) begin
          $error("digit_char mismatch: expected %0d, actual %0d", want.digit_char, ch);
          mismatches++;
        end
        if (lst !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, lst);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ura_in_if  in_if ();
  ura_out_if out_if ();

  digit_ledger ledger = new();
  bit          steady_mode;
  bit          hold_off_req;
  int          stall_cycles;
  int          radix_writes;

  unsigned_radix_to_ascii_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Result side: random back-pressure, a steady mode, and one long hold-off.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (steady_mode) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Every accepted character is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      ledger.check_digit(out_if.digit_char, out_if.last);
    end
  end

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_psel === 1'b1 && cfg_penable === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL unsigned_radix_to_ascii_unit");
      $finish;
    end
  end

  // Offers one value, with an occasional random gap first.
  task automatic send_value(input logic [IN_VALUE_W-1:0] v);
    int gap;
    if (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ledger.note_value(v);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_all_digits();
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  // Register write with a setup and an access cycle.
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (idx == int'(REG_RADIX)) begin
      ledger.set_radix(data[RADIX_W-1:0]);
      radix_writes++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Registers change only once the block has gone quiet.
  task automatic reprogram(input int idx, input logic [CFG_DATA_W-1:0] data);
    stop_sending();
    wait_all_digits();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(idx, data);
  endtask

  // Mix of full-width values, shortened values, small values and base edges.
  function automatic logic [IN_VALUE_W-1:0] pick_value();
    logic [IN_VALUE_W-1:0] v;
    logic [RADIX_W-1:0]    b;
    longint unsigned       p;
    int                    n;
    b = ledger.effective_base();
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom >> $urandom_range(31);
      5:       v = $urandom_range(20);
      6: begin
        // A power of the base, or one below it (all top digits).
        p = 1;
        n = $urandom_range(1, 32);
        repeat (n) begin
          if (p * b <= 64'hFFFF_FFFF) p = p * b;
        end
        v = IN_VALUE_W'(p - $urandom_range(1));
      end
      7:       v = '1;
      default: v = IN_VALUE_W'(1) << $urandom_range(IN_VALUE_W - 1);
    endcase
    return v;
  endfunction

  task automatic run_phase(input logic [RADIX_W-1:0] setting, input bit steady,
                           input bit with_hold, input bit with_pause);
    int i;
    reprogram(int'(REG_RADIX), CFG_DATA_W'(setting));
    steady_mode = steady;
    for (i = 0; i < PHASE_VALUES; i++) begin
      if (with_hold && i == 4) begin
        hold_off_req = 1'b1;
      end
      if (with_pause && i == PHASE_VALUES / 2) begin
        stop_sending();
        wait_all_digits();
      end
      send_value(pick_value());
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    steady_mode  = 1'b0;
    hold_off_req = 1'b0;
    stall_cycles = 0;
    radix_writes = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Decimal after reset: zero, single digits, the ten-digit extremes.
    send_value('0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd999_999_999);
    send_value(32'd1_000_000_000);
    send_value('1);

    // Binary gives the longest strings.
    reprogram(int'(REG_RADIX), CFG_DATA_W'(RADIX_MIN));
    send_value('0);
    send_value(32'd1);
    send_value(32'h8000_0000);
    send_value('1);

    // Base settings of zero and one saturate to binary.
    reprogram(int'(REG_RADIX), '0);
    send_value(32'd6);
    reprogram(int'(REG_RADIX), CFG_DATA_W'(1));
    send_value(32'd3);

    // Base settings above ten saturate to decimal.
    reprogram(int'(REG_RADIX), CFG_DATA_W'(15));
    send_value(32'd12345);
    reprogram(int'(REG_RADIX), CFG_DATA_W'(11));
    send_value(32'd10);

    // A write to an unused register leaves the base alone.
    reprogram(UNUSED_REG_IDX, CFG_DATA_W'(RADIX_MIN));
    send_value(32'd100);

    reprogram(int'(REG_RADIX), CFG_DATA_W'(9));
    send_value(32'd8);
    send_value(32'd9);
    send_value(32'd80);

    // Random values under several bases, with one steady stretch, one long
    // result-side hold-off and one pause on the input side.
    run_phase(4'd3, 1'b0, 1'b0, 1'b0);
    run_phase(RADIX_MAX, 1'b1, 1'b0, 1'b0);
    run_phase(RADIX_MIN, 1'b0, 1'b1, 1'b0);
    run_phase(4'd7, 1'b0, 1'b0, 1'b1);
    run_phase(4'd5, 1'b0, 1'b0, 1'b0);
    run_phase(4'd13, 1'b0, 1'b0, 1'b0);

    stop_sending();
    wait_all_digits();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d checked characters over %0d base writes.",
             ledger.values_noted, ledger.digits_checked, radix_writes);
    $display("Effective bases used, bit n for base n: %b", ledger.bases_used[10:2]);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("PASS unsigned_radix_to_ascii_unit");
    end else begin
      $display("FAIL unsigned_radix_to_ascii_unit");
    end
    $finish;
  end

endmodule
